// ----- rtl/redqa_pkg.sv -----
// redqa_pkg: widths, register indexes, operation codes and shared types
// for the red queue admission block; no dependencies
package redqa_pkg;

   localparam int QUEUE_DEPTH       = 32;
   localparam int WORD_WIDTH        = 32;
   localparam int AVG_FRACTION_BITS = 8;

   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OCC_W      = 6;
   localparam int CFG_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int AVG_W      = 13;
   localparam int PCT_W      = 7;
   localparam int PICK_W     = 7;
   localparam int CNT_W      = 32;
   localparam int TH_W       = CFG_W + AVG_FRACTION_BITS;
   localparam int NUM_W      = TH_W + PCT_W;
   localparam int STEP_W     = $clog2(PCT_W);
   localparam int SUM_W      = OCC_W + AVG_FRACTION_BITS + 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 120;

   localparam logic [AVG_W-1:0] AVG_MAX  = '1;
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT   = 2'd2;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_DEPART  = 1'b1;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] quot;
   } div_status_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

// ----- rtl/red_queue_admission.sv -----
// red_queue_admission: queue of packet words with random early detection
// depends on redqa_pkg, redqa_divider, redqa_store
//
//   channel   direction  handshake            contents
//   req_      in         tvalid/tready        tuser op, tdata word and pick
//   rsp_      out        tvalid/tready        tdata verdict, word, levels
//   csr_      in         we                   index, 6-bit data
//
// a departure or a decided arrival passes the average, compare and final steps
// after its accept, then raises rsp_tvalid and req_tready in the same cycle;
// an arrival inside the ramp also waits in the divide step for the 7 quotient
// steps of the divider and its done flag; req_tready is high only between
// transactions; the result register lets the next transaction in while one
// waits; a stalled result holds the block in its final step
// synchronous reset; no memory clearing pass
module red_queue_admission (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_tuser,  // op
   input  logic [redqa_pkg::REQ_DATA_W-1:0]     req_tdata,  // packet_word, random_pick
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // admitted, forwarded, head_word, empty_error, fill_level, average_fill,
   // admitted_total, dropped_total
   output logic [redqa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [redqa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [redqa_pkg::CFG_W-1:0]          csr_wdata
);
   import redqa_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AVG  = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CFG_W-1:0]      min_ff, min_in;
   logic [CFG_W-1:0]      max_ff, max_in;
   logic [CFG_W-1:0]      limit_ff, limit_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [AVG_W-1:0]      avg_ff, avg_in;
   logic [CNT_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      rej_ff, rej_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  op_ff, op_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [PICK_W-1:0]     pick_ff, pick_in;
   logic                  verdict_ff, verdict_in;

   logic [SUM_W-1:0]      avg_sum;
   logic [SUM_W-2:0]      avg_half;
   logic [TH_W-1:0]       lo_level, hi_level, avg_ext, gap, diff;
   logic                  full;
   logic                  out_free, commit;
   logic                  adm, fwd, err;
   logic [OCC_W-1:0]      occ_next;
   logic [CNT_W-1:0]      acc_next, rej_next;
   logic [WORD_WIDTH-1:0] head_word, rd_data;
   logic                  div_start, mem_we, mem_re;
   logic [NUM_W-1:0]      div_num;
   div_status_type        div_st;

   redqa_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (gap),
      .status (div_st)
   );

   redqa_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tail_ff),
      .wr_data (word_ff),
      .rd_en   (mem_re),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign avg_sum  = SUM_W'(avg_ff) + (SUM_W'(occ_ff) << AVG_FRACTION_BITS);
   assign avg_half = avg_sum[SUM_W-1:1];
   assign lo_level = TH_W'(min_ff) << AVG_FRACTION_BITS;
   assign hi_level = TH_W'(max_ff) << AVG_FRACTION_BITS;
   assign avg_ext  = TH_W'(avg_ff);
   assign gap      = hi_level - lo_level;
   assign diff     = avg_ext - lo_level;
   assign div_num  = NUM_W'(diff) * NUM_W'(PCT_FULL);
   assign full     = (occ_ff >= limit_ff) || (occ_ff >= OCC_W'(QUEUE_DEPTH));

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == ST_FIN) && out_free;
   assign adm      = (op_ff == OP_ARRIVAL) && verdict_ff;
   assign fwd      = (op_ff == OP_DEPART) && (occ_ff != '0);
   assign err      = (op_ff == OP_DEPART) && (occ_ff == '0);
   assign occ_next = adm ? occ_ff + OCC_W'(1) : (fwd ? occ_ff - OCC_W'(1) : occ_ff);
   assign acc_next = (adm && (acc_ff != '1)) ? acc_ff + CNT_W'(1) : acc_ff;
   assign rej_next = ((op_ff == OP_ARRIVAL) && !verdict_ff && (rej_ff != '1))
                     ? rej_ff + CNT_W'(1) : rej_ff;
   assign head_word = fwd ? rd_data : '0;
   assign mem_we   = commit && adm;
   assign mem_re   = (state_ff == ST_CMP);
   assign div_start = (state_ff == ST_CMP) && (op_ff == OP_ARRIVAL) && !full &&
                      (avg_ext > lo_level) && (avg_ext < hi_level);

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      limit_in     = limit_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      avg_in       = avg_ff;
      acc_in       = acc_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      word_in      = word_ff;
      pick_in      = pick_ff;
      verdict_in   = verdict_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MIN_THRESHOLD: min_in   = csr_wdata;
            CSR_MAX_THRESHOLD: max_in   = csr_wdata;
            CSR_QUEUE_LIMIT:   limit_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               word_in  = req_tdata[WORD_WIDTH-1:0];
               pick_in  = req_tdata[WORD_WIDTH +: PICK_W];
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            avg_in   = (avg_half > (SUM_W-1)'(AVG_MAX)) ? AVG_MAX : avg_half[AVG_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (op_ff == OP_DEPART) begin
               state_in = ST_FIN;
            end else if (full) begin
               verdict_in = 1'b0;
               state_in   = ST_FIN;
            end else if (avg_ext <= lo_level) begin
               verdict_in = 1'b1;
               state_in   = ST_FIN;
            end else if (avg_ext >= hi_level) begin
               verdict_in = 1'b0;
               state_in   = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               verdict_in = pick_ff < (PCT_FULL - div_st.quot);
               state_in   = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               occ_in       = occ_next;
               acc_in       = acc_next;
               rej_in       = rej_next;
               if (adm) begin
                  tail_in = next_ptr(tail_ff);
               end
               if (fwd) begin
                  head_in = next_ptr(head_ff);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, rej_next, acc_next, avg_ff, occ_next, err,
                               head_word, fwd, adm};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= CFG_W'(3);
         max_ff       <= CFG_W'(17);
         limit_ff     <= CFG_W'(20);
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         avg_ff       <= '0;
         acc_ff       <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         avg_ff       <= avg_in;
         acc_ff       <= acc_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      word_ff     <= word_in;
      pick_ff     <= pick_in;
      verdict_ff  <= verdict_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   occ_bound_a: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   avg_bound_a: assert property (@(posedge clock) disable iff (reset)
      avg_ff <= AVG_MAX)
      else $error("average above its saturation level");

   div_done_a: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the ramp step");

   write_room_a: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (occ_ff < OCC_W'(QUEUE_DEPTH)) && (occ_ff < limit_ff))
      else $error("packet stored into a full queue");

   pop_data_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) && (op_ff == OP_DEPART) |=> (state_ff == ST_FIN))
      else $error("departure did not reach its final step after the read");
`endif

endmodule

// ----- rtl/redqa_divider.sv -----
// redqa_divider: restoring shift-subtract divider, one quotient bit a cycle
// depends on redqa_pkg
module redqa_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [redqa_pkg::NUM_W-1:0]  num,
   input  logic [redqa_pkg::TH_W-1:0]   den,
   output redqa_pkg::div_status_type    status
);
   import redqa_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [TH_W-1:0]   den_ff, den_in;
   logic [PCT_W-1:0]  quot_ff, quot_in;
   logic [NUM_W-1:0]  den_shift;

   assign den_shift = NUM_W'(den_ff) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PCT_W - 1);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= den_shift) begin
            rem_in           = rem_ff - den_shift;
            quot_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;

endmodule

// ----- rtl/redqa_store.sv -----
// redqa_store: packet word memory, one write and one registered read port
// depends on redqa_pkg
module redqa_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [redqa_pkg::PTR_W-1:0]      wr_addr,
   input  logic [redqa_pkg::WORD_WIDTH-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [redqa_pkg::PTR_W-1:0]      rd_addr,
   output logic [redqa_pkg::WORD_WIDTH-1:0] rd_data
);
   import redqa_pkg::*;

   logic [WORD_WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/testbench.sv -----
// testbench: drives the red queue admission block with directed and random
// arrival/departure traffic, predicts every result and checks it per field
// depends on redqa_pkg and red_queue_admission
module testbench;
   import redqa_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RING_DEPTH  = 8;

   // first field in the lowest bits, hence declared last
   typedef struct packed {
      logic [CNT_W-1:0]      dropped_total;
      logic [CNT_W-1:0]      admitted_total;
      logic [AVG_W-1:0]      average_fill;
      logic [OCC_W-1:0]      fill_level;
      logic                  empty_error;
      logic [WORD_WIDTH-1:0] head_word;
      logic                  forwarded;
      logic                  admitted;
   } admission_result_type;

   localparam int RESULT_BITS = $bits(admission_result_type);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = OP_ARRIVAL;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MIN_THRESHOLD;
   logic [CFG_W-1:0]      csr_wdata = '0;

   red_queue_admission dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow of the block state
   logic [WORD_WIDTH-1:0] shadow_store [QUEUE_DEPTH];
   int unsigned           shadow_head = 0;
   int unsigned           shadow_tail = 0;
   int unsigned           shadow_fill = 0;
   int unsigned           shadow_average = 0;
   logic [CNT_W-1:0]      shadow_admitted = '0;
   logic [CNT_W-1:0]      shadow_dropped = '0;
   int unsigned           min_level = 3;
   int unsigned           max_level = 17;
   int unsigned           fill_limit = 20;

   // expected results in order, written by the sender and read by the checker
   admission_result_type expected_ring [RING_DEPTH];
   int unsigned          ring_wr = 0;
   int unsigned          ring_rd = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          idle_pct = 10;
   int unsigned          stall_left = 0;

   function automatic admission_result_type predict_admission(logic op,
                                                             logic [WORD_WIDTH-1:0] word,
                                                             logic [PICK_W-1:0] pick);
      admission_result_type r;
      int unsigned          sum;
      int unsigned          lo;
      int unsigned          hi;
      int unsigned          pct;
      bit                   take;
      r = '0;
      sum = (shadow_average + (shadow_fill << AVG_FRACTION_BITS)) >> 1;
      shadow_average = (sum > 8191) ? 8191 : sum;
      if (op == OP_ARRIVAL) begin
         lo = min_level << AVG_FRACTION_BITS;
         hi = max_level << AVG_FRACTION_BITS;
         if (shadow_fill >= fill_limit || shadow_fill >= QUEUE_DEPTH) begin
            take = 1'b0;
         end else if (shadow_average <= lo) begin
            take = 1'b1;
         end else if (shadow_average >= hi) begin
            take = 1'b0;
         end else begin
            pct = (100 * (shadow_average - lo)) / (hi - lo);
            if (pct > 100) pct = 100;
            take = (pick < 100 - pct);
         end
         if (take) begin
            shadow_store[shadow_tail] = word;
            shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
            shadow_fill++;
            r.admitted = 1'b1;
            if (shadow_admitted != '1) shadow_admitted++;
         end else begin
            if (shadow_dropped != '1) shadow_dropped++;
         end
      end else if (shadow_fill == 0) begin
         r.empty_error = 1'b1;
      end else begin
         r.head_word = shadow_store[shadow_head];
         r.forwarded = 1'b1;
         shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
         shadow_fill--;
      end
      r.fill_level = OCC_W'(shadow_fill);
      r.average_fill = AVG_W'(shadow_average);
      r.admitted_total = shadow_admitted;
      r.dropped_total = shadow_dropped;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, field, got, want);
   endtask

   task automatic store_expected(admission_result_type r);
      expected_ring[ring_wr % RING_DEPTH] = r;
      ring_wr++;
   endtask

   // one transaction on the request channel; valid stays high for the next call
   task automatic send_item(logic op, logic [WORD_WIDTH-1:0] word, logic [PICK_W-1:0] pick);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'({pick, word});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      store_expected(predict_admission(op, word, pick));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (ring_wr != ring_rd) @(posedge clock);
   endtask

   task automatic set_thresholds(int unsigned lo, int unsigned hi, int unsigned limit);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_THRESHOLD;
      csr_wdata <= CFG_W'(lo);
      @(posedge clock);
      csr_index <= CSR_MAX_THRESHOLD;
      csr_wdata <= CFG_W'(hi);
      @(posedge clock);
      csr_index <= CSR_QUEUE_LIMIT;
      csr_wdata <= CFG_W'(limit);
      @(posedge clock);
      csr_we <= 1'b0;
      min_level = lo & 6'h3f;
      max_level = hi & 6'h3f;
      fill_limit = limit & 6'h3f;
   endtask

   task automatic run_traffic(int unsigned count);
      int unsigned arrival_pct;
      logic [PICK_W-1:0] pick;
      for (int unsigned i = 0; i < count; i++) begin
         arrival_pct = ((i / 40) % 2 == 0) ? 75 : 35;
         pick = ($urandom_range(0, 9) == 0) ? PICK_W'($urandom_range(0, 127))
                                            : PICK_W'($urandom_range(0, 100));
         send_item(($urandom_range(0, 99) < arrival_pct) ? OP_ARRIVAL : OP_DEPART,
                   $urandom, pick);
      end
   endtask

   task automatic test_empty_departure();
      send_item(OP_DEPART, 32'h0, 7'd0);
      send_item(OP_DEPART, 32'hffff_ffff, 7'd127);
   endtask

   task automatic test_field_extremes();
      send_item(OP_ARRIVAL, 32'h0000_0000, 7'd0);
      send_item(OP_ARRIVAL, 32'hffff_ffff, 7'd127);
      send_item(OP_ARRIVAL, 32'ha5a5_5a5a, 7'd100);
      send_item(OP_DEPART, 32'h0, 7'd0);
      send_item(OP_DEPART, 32'h0, 7'd0);
      send_item(OP_DEPART, 32'h0, 7'd0);
   endtask

   // narrow ramp so that picks above and below the cut are both seen
   task automatic test_ramp_edges();
      set_thresholds(0, 2, 32);
      send_item(OP_ARRIVAL, 32'h1111_1111, 7'd127);
      send_item(OP_ARRIVAL, 32'h2222_2222, 7'd0);
      send_item(OP_ARRIVAL, 32'h3333_3333, 7'd101);
      send_item(OP_ARRIVAL, 32'h4444_4444, 7'd99);
      send_item(OP_ARRIVAL, 32'h5555_5555, 7'd0);
   endtask

   task automatic test_threshold_order();
      set_thresholds(1, 1, 32);
      send_item(OP_ARRIVAL, 32'h6666_6666, 7'd0);
      set_thresholds(9, 1, 32);
      send_item(OP_ARRIVAL, 32'h7777_7777, 7'd0);
      send_item(OP_ARRIVAL, 32'h8888_8888, 7'd50);
   endtask

   task automatic test_queue_full();
      set_thresholds(63, 63, 0);
      send_item(OP_ARRIVAL, 32'h9999_9999, 7'd0);
      send_item(OP_DEPART, 32'h0, 7'd0);
      set_thresholds(63, 63, 1);
      repeat (6) send_item(OP_DEPART, 32'h0, 7'd0);
      send_item(OP_ARRIVAL, 32'haaaa_aaaa, 7'd0);
      send_item(OP_ARRIVAL, 32'hbbbb_bbbb, 7'd0);
   endtask

   // fill to the full depth so the average climbs to its ceiling
   task automatic test_deep_queue();
      set_thresholds(63, 63, 32);
      for (int unsigned i = 0; i < 90; i++)
         send_item(($urandom_range(0, 99) < 85) ? OP_ARRIVAL : OP_DEPART, $urandom,
                   PICK_W'($urandom_range(0, 127)));
      repeat (40) send_item(OP_DEPART, $urandom, PICK_W'($urandom_range(0, 127)));
   endtask

   task automatic test_random_settings();
      int unsigned lo;
      int unsigned hi;
      set_thresholds(0, 32, 32);
      run_traffic(150);
      set_thresholds(32, 0, 1);
      run_traffic(60);
      for (int unsigned phase = 0; phase < 6; phase++) begin
         lo = $urandom_range(0, 20);
         hi = lo + $urandom_range(1, 12);
         idle_pct = (phase % 3 == 2) ? 0 : 12;
         set_thresholds(lo, hi, $urandom_range(1, 32));
         run_traffic(125);
      end
   endtask

   task automatic test_quiet_tail();
      idle_pct = 0;
      set_thresholds(2, 10, 16);
      run_traffic(200);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      admission_result_type got;
      admission_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = admission_result_type'(rsp_tdata[RESULT_BITS-1:0]);
         if (ring_wr == ring_rd) begin
            report_mismatch("unexpected transaction", 64'(got.fill_level), 64'h0);
         end else begin
            want = expected_ring[ring_rd % RING_DEPTH];
            ring_rd++;
            if (got.admitted !== want.admitted)
               report_mismatch("admitted", 64'(got.admitted), 64'(want.admitted));
            if (got.forwarded !== want.forwarded)
               report_mismatch("forwarded", 64'(got.forwarded), 64'(want.forwarded));
            if (got.head_word !== want.head_word)
               report_mismatch("head_word", 64'(got.head_word), 64'(want.head_word));
            if (got.empty_error !== want.empty_error)
               report_mismatch("empty_error", 64'(got.empty_error), 64'(want.empty_error));
            if (got.fill_level !== want.fill_level)
               report_mismatch("fill_level", 64'(got.fill_level), 64'(want.fill_level));
            if (got.average_fill !== want.average_fill)
               report_mismatch("average_fill", 64'(got.average_fill),
                               64'(want.average_fill));
            if (got.admitted_total !== want.admitted_total)
               report_mismatch("admitted_total", 64'(got.admitted_total),
                               64'(want.admitted_total));
            if (got.dropped_total !== want.dropped_total)
               report_mismatch("dropped_total", 64'(got.dropped_total),
                               64'(want.dropped_total));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit reached");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_departure();
      test_field_extremes();
      test_ramp_edges();
      test_threshold_order();
      test_queue_full();
      test_deep_queue();
      test_random_settings();
      test_quiet_tail();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
